/* rtl/core/frame_buffer_ring_manager_top_assert.svh */
// Assertion macros for the frame buffer ring manager checks.
// Both sample on clk_i and are held off while rst_ni is low.
`ifndef FRAME_BUFFER_RING_MANAGER_TOP_ASSERT_SVH
`define FRAME_BUFFER_RING_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define FRB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frb check failed");

// Next-cycle implication.
`define FRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frb check failed");

`endif

/* rtl/core/frb_pkg.sv */
package frb_pkg;

  localparam int unsigned NUM_SLOTS_DEF       = 4;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 32768;

  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned SLOT_IDX_W = 2;

  // slot status codes
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_FILLING = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;

  // request kinds
  localparam logic OP_FRAME_DONE = 1'b0;
  localparam logic OP_TAKE       = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] frame_size;
  } req_t;

  typedef struct packed {
    logic                  accepted;
    logic                  dropped;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [SIZE_W-1:0]     frame_length;
  } res_t;

endpackage

/* rtl/core/frb_in_stage.sv */
module frb_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  frb_pkg::req_t req_i,
  output logic          valid_o,
  input  logic          take_i,
  output frb_pkg::req_t req_o
);
  import frb_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

/* rtl/core/frb_ring_core.sv */
module frb_ring_core #(
  parameter int unsigned NUM_SLOTS       = frb_pkg::NUM_SLOTS_DEF,
  parameter int unsigned MAX_FRAME_BYTES = frb_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  frb_pkg::req_t req_i,
  output frb_pkg::res_t res_o
);
  import frb_pkg::*;

  localparam int unsigned PtrW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(NUM_SLOTS - 1);
  localparam logic [SIZE_W-1:0] MaxLen = SIZE_W'(MAX_FRAME_BYTES);

  logic [1:0]        status_q [NUM_SLOTS];
  logic [1:0]        status_d [NUM_SLOTS];
  logic [SIZE_W-1:0] length_q [NUM_SLOTS];
  logic [PtrW-1:0]   fill_q, fill_d, take_q, take_d;
  logic [PtrW-1:0]   fill_nxt, take_nxt;
  logic [SIZE_W-1:0] size_sat;
  logic              len_we;
  res_t              res;

  assign fill_nxt = (fill_q == LastSlot) ? '0 : fill_q + 1'b1;
  assign take_nxt = (take_q == LastSlot) ? '0 : take_q + 1'b1;
  assign size_sat = (req_i.frame_size > MaxLen) ? MaxLen : req_i.frame_size;

  always_comb begin
    status_d = status_q;
    fill_d   = fill_q;
    take_d   = take_q;
    len_we   = 1'b0;
    res      = '0;
    case (req_i.opcode)
      OP_FRAME_DONE: begin
        if (status_q[fill_nxt] == ST_FREE) begin
          len_we             = 1'b1;
          status_d[fill_q]   = ST_READY;
          status_d[fill_nxt] = ST_FILLING;
          fill_d             = fill_nxt;
          res.accepted       = 1'b1;
          res.slot_index     = SLOT_IDX_W'(32'(fill_nxt));
        end else begin
          res.dropped    = 1'b1;
          res.slot_index = SLOT_IDX_W'(32'(fill_q));
        end
      end
      OP_TAKE: begin
        if (status_q[take_q] == ST_READY) begin
          status_d[take_q] = ST_FREE;
          take_d           = take_nxt;
          res.accepted     = 1'b1;
          res.slot_index   = SLOT_IDX_W'(32'(take_q));
          res.frame_length = length_q[take_q];
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_q[i] <= (i == 0) ? ST_FILLING : ST_FREE;
      end
      fill_q <= '0;
      take_q <= '0;
    end else if (fire_i) begin
      status_q <= status_d;
      fill_q   <= fill_d;
      take_q   <= take_d;
    end
  end

  // lengths are only read once their slot is ready, so no reset
  always_ff @(posedge clk_i) begin
    if (fire_i && len_we) begin
      length_q[fill_q] <= size_sat;
    end
  end

  assign res_o = res;

endmodule

/* rtl/core/frb_out_stage.sv */
module frb_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  frb_pkg::res_t res_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output frb_pkg::res_t res_o
);
  import frb_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* rtl/core/frame_buffer_ring_manager_top.sv */
// Frame buffer ring manager: ring of receive slots, commit-or-drop and take.
// An accepted input word passes through the input register, then the result register.
// Throughput: one word per cycle while the master side takes results; the slot state
// updates in the cycle a word moves from the input register to the result register.
// Reset (rst_ni low, async): slot 0 filling, all others free, both pointers 0,
// both word registers empty.
module frame_buffer_ring_manager_top #(
  parameter int unsigned NUM_SLOTS       = frb_pkg::NUM_SLOTS_DEF,
  parameter int unsigned MAX_FRAME_BYTES = frb_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] frame_size
  input  logic        s_axis_tuser,   // [0] opcode (0 frame done, 1 take)
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] slot_index, [17:2] frame_length, rest 0
  output logic [1:0]  m_axis_tuser    // [0] accepted, [1] dropped
);
  import frb_pkg::*;

  req_t req_in, req_q;
  res_t res_c, res_q;
  logic req_valid, out_space, fire;

  assign req_in.opcode     = s_axis_tuser;
  assign req_in.frame_size = s_axis_tdata;

  // a held request is processed as soon as the result register has room
  assign fire = req_valid && out_space;

  frb_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .req_i   (req_in),
    .valid_o (req_valid),
    .take_i  (fire),
    .req_o   (req_q)
  );

  frb_ring_core #(
    .NUM_SLOTS       (NUM_SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .res_o  (res_c)
  );

  frb_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (res_c),
    .space_o (out_space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_q)
  );

  assign m_axis_tdata = {6'd0, res_q.frame_length, res_q.slot_index};
  assign m_axis_tuser = {res_q.dropped, res_q.accepted};

endmodule

/* rtl/core/frb_checker.sv */
`include "frame_buffer_ring_manager_top_assert.svh"

module frb_checker #(
  parameter int unsigned MAX_FRAME_BYTES = frb_pkg::MAX_FRAME_BYTES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import frb_pkg::*;

  localparam logic [16:0] MaxLen = 17'(MAX_FRAME_BYTES);

  // stalled result word holds
  `FRB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a word is never both committed and dropped
  `FRB_ASSERT_IMPLY(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

  // a take with nothing ready reports all zeros
  `FRB_ASSERT_IMPLY(a_empty_zero, m_axis_tvalid && (m_axis_tuser == 2'b00),
                    m_axis_tdata == 24'd0)

  // handed-out lengths never exceed the buffer size; drops carry none
  `FRB_ASSERT_IMPLY(a_len_bound, m_axis_tvalid,
                    ({1'b0, m_axis_tdata[17:2]} <= MaxLen) &&
                    (!m_axis_tuser[1] || (m_axis_tdata[17:2] == 16'd0)))

endmodule

bind frame_buffer_ring_manager_top frb_checker #(
  .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
) u_frb_checker (.*);

/* tb/tb_frame_buffer_ring_manager_top.sv */
module tb_frame_buffer_ring_manager_top;
  import frb_pkg::*;

  localparam int unsigned SLOTS     = NUM_SLOTS_DEF;
  localparam int unsigned MAX_BYTES = MAX_FRAME_BYTES_DEF;
  localparam int unsigned RAND_WORDS = 1710;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] frame_size
  logic        s_axis_tuser;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [1:0] slot_index, [17:2] frame_length
  logic [1:0]  m_axis_tuser;   // [0] accepted, [1] dropped

  frame_buffer_ring_manager_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Shadow copy of the slot ring
  logic [1:0]            slot_state [SLOTS];
  logic [SIZE_W-1:0]     slot_len   [SLOTS];
  logic [SLOT_IDX_W-1:0] fill_ptr;
  logic [SLOT_IDX_W-1:0] take_ptr;

  res_t slot_reply_q [$];
  int   mismatches;

  // Idling knobs, changed between phases
  bit src_idle;
  bit sink_idle;
  int sink_hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run guard: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [SLOT_IDX_W-1:0] ring_next(input logic [SLOT_IDX_W-1:0] p);
    return (p == SLOT_IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one request word to the shadow ring and returns the reply it causes
  function automatic res_t ring_advance(input logic op, input logic [SIZE_W-1:0] size);
    res_t                  r;
    logic [SLOT_IDX_W-1:0] nxt;
    logic [SIZE_W-1:0]     len;
    r = '0;
    if (op == OP_FRAME_DONE) begin
      nxt = ring_next(fill_ptr);
      len = (size > MAX_BYTES) ? SIZE_W'(MAX_BYTES) : size;
      if (slot_state[nxt] == ST_FREE) begin
        slot_len[fill_ptr]   = len;
        slot_state[fill_ptr] = ST_READY;
        fill_ptr             = nxt;
        slot_state[nxt]      = ST_FILLING;
        r.accepted           = 1'b1;
      end else begin
        // next slot busy: frame lost, same slot refills
        r.dropped = 1'b1;
      end
      r.slot_index = fill_ptr;
    end else if (slot_state[take_ptr] == ST_READY) begin
      r.accepted           = 1'b1;
      r.slot_index         = take_ptr;
      r.frame_length       = slot_len[take_ptr];
      slot_state[take_ptr] = ST_FREE;
      take_ptr             = ring_next(take_ptr);
    end
    return r;
  endfunction

  // Offers one request word and returns in the step it is taken
  task automatic send_req(input logic op, input logic [SIZE_W-1:0] size);
    int gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= size;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    slot_reply_q.push_back(ring_advance(op, size));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (slot_reply_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Result side: one stall draw per word, long hold-off when asked
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = sink_idle ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Reply checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (slot_reply_q.size() == 0) begin
        $error("reply word with nothing outstanding: tuser %b tdata %h",
               m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = slot_reply_q.pop_front();
        if (m_axis_tuser[0] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tdata[1:0] !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, m_axis_tdata[1:0]);
          mismatches++;
        end
        if (m_axis_tdata[17:2] !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 m_axis_tdata[17:2]);
          mismatches++;
        end
      end
    end
  end

  // Take on a freshly reset ring finds nothing
  task automatic test_take_empty;
    send_req(OP_TAKE, 16'hFFFF);
    send_req(OP_TAKE, 16'h0000);
  endtask

  // Fill the ring up to the drop point, with size extremes and saturation
  task automatic test_fill_and_drop;
    send_req(OP_FRAME_DONE, 16'd0);
    send_req(OP_FRAME_DONE, 16'(MAX_BYTES));
    send_req(OP_FRAME_DONE, 16'hFFFF);
    send_req(OP_FRAME_DONE, 16'(MAX_BYTES + 1));
    send_req(OP_FRAME_DONE, 16'd1);
  endtask

  // Empty the ring, then one take more than there are ready frames
  task automatic test_take_all;
    repeat (4) send_req(OP_TAKE, 16'h0000);
  endtask

  // Walk both pointers round the wrap with alternating bit patterns
  task automatic test_wrap;
    send_req(OP_FRAME_DONE, 16'h5555);
    send_req(OP_FRAME_DONE, 16'hAAAA);
    send_req(OP_TAKE, 16'h0000);
    send_req(OP_FRAME_DONE, 16'h7FFF);
    send_req(OP_FRAME_DONE, 16'h2AAA);
    send_req(OP_TAKE, 16'hFFFF);
    send_req(OP_TAKE, 16'h0000);
    send_req(OP_TAKE, 16'h0000);
    send_req(OP_TAKE, 16'h0000);
  endtask

  // Result side holds off for a long stretch while requests keep coming
  task automatic test_backpressure;
    int i;
    src_idle         = 1'b0;
    sink_idle        = 1'b0;
    sink_hold_cycles = 80;
    for (i = 0; i < 24; i++) begin
      send_req((i % 3 == 2) ? OP_TAKE : OP_FRAME_DONE, 16'($urandom_range(0, 2000)));
    end
    drain();
  endtask

  // Random mix; take bias per phase swings the ring between full and empty
  task automatic test_random_traffic;
    int          i;
    int          take_pct;
    int          pick;
    logic [15:0] size;
    take_pct = 50;
    for (i = 0; i < RAND_WORDS; i++) begin
      if (i % 50 == 0) begin
        take_pct  = $urandom_range(0, 4) * 20 + 10;
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 3);
      case (pick)
        0:       size = 16'($urandom_range(0, 16'hFFFF));
        1:       size = 16'($urandom_range(MAX_BYTES - 8, MAX_BYTES + 8));
        default: size = 16'($urandom_range(0, MAX_BYTES));
      endcase
      send_req(($urandom_range(1, 100) <= take_pct) ? OP_TAKE : OP_FRAME_DONE, size);
    end
    drain();
  endtask

  initial begin
    mismatches       = 0;
    sink_hold_cycles = 0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    fill_ptr         = '0;
    take_ptr         = '0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_state[s] = ST_FREE;
      slot_len[s]   = '0;
    end
    slot_state[0] = ST_FILLING;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_FRAME_DONE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_take_empty();
    test_fill_and_drop();
    test_take_all();
    test_wrap();
    drain();
    test_backpressure();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
